@@ design/fbfl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the fixed block free list allocator.
// No dependencies; every other design file but fbfl_link_mem imports this package.
package fbfl_pkg;

    localparam int SHIFT_W  = 5;
    localparam int OFFSET_W = 26;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd10;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] free_idx;
        logic                free_out_of_range;
        logic [OFFSET_W-1:0] alloc_offset;
    } conv_t;

endpackage

@@ design/fbfl_link_mem.sv @@
`timescale 1ns / 1ps
// Synchronous link memory of the free list: one write port, one read port.
// Read data is registered and appears in the cycle after the read enable.
module fbfl_link_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 11
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/fbfl_offset_conv.sv @@
`timescale 1ns / 1ps
// Offset and index conversion by the block size exponent.
// Depends on fbfl_pkg for field widths and the conversion result struct.
module fbfl_offset_conv #(
    parameter int NUM_BLOCKS = 1024,
    parameter int LINK_W     = 11
) (
    input  logic [fbfl_pkg::SHIFT_W-1:0]  block_shift,
    input  logic [fbfl_pkg::OFFSET_W-1:0] block_offset,
    input  logic [LINK_W-1:0]             head,
    output fbfl_pkg::conv_t               conv
);

    import fbfl_pkg::*;

    localparam logic [OFFSET_W-1:0] NUM_BLOCKS_OFS = OFFSET_W'(NUM_BLOCKS);

    logic [OFFSET_W-1:0] free_idx;

    always_comb
    begin
        free_idx                = block_offset >> block_shift;
        conv.free_idx           = free_idx;
        conv.free_out_of_range  = (free_idx >= NUM_BLOCKS_OFS);
        conv.alloc_offset       = OFFSET_W'(head) << block_shift;
    end

endmodule

@@ design/fixed_block_free_list_allocator_unit.sv @@
`timescale 1ns / 1ps
// Top level of the fixed block free list allocator.
// Depends on fbfl_pkg, fbfl_link_mem and fbfl_offset_conv.
//
// Usage:
// The input channel carries one request per beat: mode selects allocate or
// free, and block_offset gives the byte offset of the block to free. Each
// request yields exactly one result beat on the output channel with a
// status, the block index and, for an allocate, the byte offset.
// The block size exponent, reset to 10, is set through cfg_we and cfg_wdata;
// the user must write it only while the block is idle; it is not enforced.
// An allocate from a non-empty list enters S_READ, since the link of the
// head block is read from the synchronous link memory before the head can
// move. A free, an allocate from an empty list and a rejected free are
// answered from S_IDLE; their result sits in the output register in the
// cycle after accept. A link read puts its result there as S_READ ends.
// After reset the block runs an initialization pass over all NUM_BLOCKS
// blocks, chaining each block to the next; in_stall stays high until it ends.
// While the receiver holds out_stall, the result beat is held unchanged and
// no new request is taken; an allocate in flight waits with its read data.
module fixed_block_free_list_allocator_unit #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fbfl_pkg::SHIFT_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [fbfl_pkg::OFFSET_W-1:0] block_offset,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fbfl_pkg::STATUS_W-1:0] status,
    output logic [fbfl_pkg::INDEX_W-1:0]  block_index,
    output logic [fbfl_pkg::OFFSET_W-1:0] byte_offset
);

    import fbfl_pkg::*;

    localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [LINK_W-1:0] END_MARK  = LINK_W'(NUM_BLOCKS);
    localparam logic [LINK_W-1:0] INIT_LAST = LINK_W'(NUM_BLOCKS - 1);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_READ
    } state_t;

    state_t               state_reg, state_next;
    logic [LINK_W-1:0]    head_reg, head_next;
    logic [LINK_W-1:0]    init_cnt_reg, init_cnt_next;
    logic [SHIFT_W-1:0]   block_shift_reg, block_shift_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg, status_next;
    logic [INDEX_W-1:0]   block_index_reg, block_index_next;
    logic [OFFSET_W-1:0]  byte_offset_reg, byte_offset_next;

    logic                 in_accept;
    logic                 out_free;
    logic                 head_empty;
    conv_t                conv;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [LINK_W-1:0]    mem_wdata;
    logic                 mem_re;
    logic [LINK_W-1:0]    mem_rdata;

    fbfl_offset_conv #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .LINK_W     (LINK_W)
    ) u_conv (
        .block_shift  (block_shift_reg),
        .block_offset (block_offset),
        .head         (head_reg),
        .conv         (conv)
    );

    fbfl_link_mem #(
        .DEPTH  (NUM_BLOCKS),
        .ADDR_W (IDX_W),
        .DATA_W (LINK_W)
    ) u_link_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (head_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE) || !out_free;
    assign in_accept  = in_valid && !in_stall;
    assign head_empty = (head_reg >= END_MARK);

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        init_cnt_next    = init_cnt_reg;
        block_shift_next = cfg_we ? cfg_wdata : block_shift_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        block_index_next = block_index_reg;
        byte_offset_next = byte_offset_reg;
        mem_we           = 1'b0;
        mem_waddr        = init_cnt_reg[IDX_W-1:0];
        mem_wdata        = init_cnt_reg + LINK_W'(1);
        mem_re           = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                mem_we        = 1'b1;
                init_cnt_next = init_cnt_reg + LINK_W'(1);
                if (init_cnt_reg == INIT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (mode == MODE_ALLOC)
                    begin
                        if (head_empty)
                        begin
                            out_valid_next   = 1'b1;
                            status_next      = STATUS_EMPTY;
                            block_index_next = '0;
                            byte_offset_next = '0;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        out_valid_next   = 1'b1;
                        block_index_next = conv.free_idx[INDEX_W-1:0];
                        byte_offset_next = '0;
                        if (conv.free_out_of_range)
                        begin
                            status_next = STATUS_RANGE;
                        end
                        else
                        begin
                            status_next = STATUS_OK;
                            mem_we      = 1'b1;
                            mem_waddr   = conv.free_idx[IDX_W-1:0];
                            mem_wdata   = head_reg;
                            head_next   = conv.free_idx[LINK_W-1:0];
                        end
                    end
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = STATUS_OK;
                    block_index_next = INDEX_W'(head_reg);
                    byte_offset_next = conv.alloc_offset;
                    head_next        = mem_rdata;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            head_reg        <= '0;
            init_cnt_reg    <= '0;
            block_shift_reg <= SHIFT_RESET;
            out_valid_reg   <= 1'b0;
            status_reg      <= STATUS_OK;
            block_index_reg <= '0;
            byte_offset_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            init_cnt_reg    <= init_cnt_next;
            block_shift_reg <= block_shift_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            block_index_reg <= block_index_next;
            byte_offset_reg <= byte_offset_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign block_index = block_index_reg;
    assign byte_offset = byte_offset_reg;

`ifndef SYNTH
    // No request may enter while the link memory is being initialized.
    a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> in_stall)
        else $error("request accepted during initialization");

    // The head is always a valid block index or the end marker.
    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= END_MARK)
        else $error("head beyond end marker");

    // An allocate from a non-empty list waits for the link read.
    a_alloc_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (mode == MODE_ALLOC) && !head_empty) |=> (state_reg == S_READ))
        else $error("allocate did not start a link read");

    // An empty-pool result carries zero index and offset.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == STATUS_EMPTY))
            |-> (block_index_reg == '0) && (byte_offset_reg == '0))
        else $error("empty result with nonzero payload");
`endif

endmodule

@@ bench/fixed_block_free_list_allocator_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for fixed_block_free_list_allocator_unit: a queued beat driver,
// a port monitor and a free list predictor that checks every result beat in order.
// Depends on fbfl_pkg and the design files under design.
module fixed_block_free_list_allocator_unit_test;

    import fbfl_pkg::*;

    localparam int NUM_BLOCKS  = 1024;
    localparam int CHECK_COPY  = 0;
    localparam int PLAN_COPY   = 1;
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                req_mode;
        logic [OFFSET_W-1:0] req_offset;
    } alloc_request_t;

    typedef struct packed {
        status_t             status;
        logic [INDEX_W-1:0]  index;
        logic [OFFSET_W-1:0] offset;
    } alloc_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [SHIFT_W-1:0]  cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                mode = MODE_ALLOC;
    logic [OFFSET_W-1:0] block_offset = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  block_index;
    logic [OFFSET_W-1:0] byte_offset;

    logic [10:0]         free_list_link [2][NUM_BLOCKS];
    logic [10:0]         free_list_head [2];
    logic [SHIFT_W-1:0]  shift_setting = SHIFT_RESET;

    alloc_request_t      pending_requests [$];
    alloc_result_t       predicted_results [$];
    int                  held_blocks [$];
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    int                  idle_pct = 0;
    int                  stall_pct = 0;
    logic                in_taken = 1'b0;

    fixed_block_free_list_allocator_unit #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .block_offset(block_offset),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .block_index(block_index),
        .byte_offset(byte_offset)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic alloc_result_t advance_free_list(input int copy, input logic req_mode,
                                                        input logic [OFFSET_W-1:0] req_offset);
        alloc_result_t r;
        logic [OFFSET_W-1:0] idx;
        r.status = STATUS_OK;
        r.index = '0;
        r.offset = '0;
        if (req_mode == MODE_ALLOC)
        begin
            if (free_list_head[copy] >= NUM_BLOCKS)
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                r.index = free_list_head[copy][INDEX_W-1:0];
                r.offset = OFFSET_W'(64'(free_list_head[copy]) << shift_setting);
                free_list_head[copy] = free_list_link[copy][free_list_head[copy][INDEX_W-1:0]];
            end
        end
        else
        begin
            idx = req_offset >> shift_setting;
            r.index = idx[INDEX_W-1:0];
            if (idx >= NUM_BLOCKS)
            begin
                r.status = STATUS_RANGE;
            end
            else
            begin
                free_list_link[copy][idx[INDEX_W-1:0]] = free_list_head[copy];
                free_list_head[copy] = idx[10:0];
            end
        end
        return r;
    endfunction

    function automatic void queue_request(input logic req_mode,
                                          input logic [OFFSET_W-1:0] req_offset);
        alloc_result_t planned;
        planned = advance_free_list(PLAN_COPY, req_mode, req_offset);
        pending_requests.push_back('{req_mode, req_offset});
        if (planned.status == STATUS_OK && req_mode == MODE_ALLOC)
        begin
            held_blocks.push_back(int'(planned.index));
        end
        else if (planned.status == STATUS_OK)
        begin
            for (int k = held_blocks.size() - 1; k >= 0; k--)
            begin
                if (held_blocks[k] == int'(planned.index))
                begin
                    held_blocks.delete(k);
                end
            end
        end
    endfunction

    // Mostly allocations and frees of blocks that are really held, with unaligned low bits;
    // the rest are raw offsets and, where allowed, frees of arbitrary blocks.
    function automatic void queue_random_items(input int count, input int alloc_pct,
                                               input bit allow_double);
        int pick;
        int slot;
        logic [63:0] base;
        logic [63:0] low_mask;
        logic [OFFSET_W-1:0] raw;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            raw = OFFSET_W'($urandom());
            low_mask = (64'd1 << shift_setting) - 64'd1;
            base = 64'd1 << OFFSET_W;
            if (pick >= alloc_pct && pick < 90 && held_blocks.size() != 0)
            begin
                slot = $urandom_range(held_blocks.size() - 1);
                base = 64'(held_blocks[slot]) << shift_setting;
            end
            else if (pick >= 95 && allow_double)
            begin
                base = 64'($urandom_range(NUM_BLOCKS - 1)) << shift_setting;
            end
            if (base < (64'd1 << OFFSET_W))
            begin
                queue_request(MODE_FREE, OFFSET_W'(base | (64'(raw) & low_mask)));
            end
            else if (pick >= 90 && (allow_double || (64'(raw) >> shift_setting) >= NUM_BLOCKS))
            begin
                queue_request(MODE_FREE, raw);
            end
            else
            begin
                queue_request(MODE_ALLOC, raw);
            end
        end
    endfunction

    task automatic wait_idle;
        while (pending_requests.size() != 0 || in_valid || predicted_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic write_block_shift(input logic [SHIFT_W-1:0] value);
        @(negedge clk);
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(negedge clk)
    begin : drive_requests
        alloc_request_t next_req;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (!in_valid || in_taken)
        begin
            if (rst_n && pending_requests.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                next_req = pending_requests.pop_front();
                mode <= next_req.req_mode;
                block_offset <= next_req.req_offset;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : watch_ports
        alloc_result_t want;
        alloc_result_t got;
        cycle_count <= cycle_count + 1;
        in_taken <= in_valid && !in_stall;
        if (cfg_we)
        begin
            shift_setting = cfg_wdata;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got.status = status_t'(status);
            got.index = block_index;
            got.offset = byte_offset;
            if (predicted_results.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                begin
                    $display("Unexpected result beat: status %0d index %0d offset 'h%0h",
                             got.status, got.index, got.offset);
                end
                mismatch_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                if (got.status !== want.status || got.index !== want.index ||
                    got.offset !== want.offset)
                begin
                    if (mismatch_count < MAX_REPORTS)
                    begin
                        $display("Mismatch: expected status %0d index %0d offset 'h%0h, %s",
                                 want.status, want.index, want.offset,
                                 $sformatf("got status %0d index %0d offset 'h%0h",
                                           got.status, got.index, got.offset));
                    end
                    mismatch_count++;
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            predicted_results.push_back(advance_free_list(CHECK_COPY, mode, block_offset));
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        for (int c = 0; c < 2; c++)
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                free_list_link[c][i] = 11'(i + 1);
            end
            free_list_head[c] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_request(MODE_ALLOC, '1);
        queue_request(MODE_ALLOC, '0);
        queue_request(MODE_ALLOC, 26'h155_5555);
        queue_request(MODE_FREE, 26'h000_0000);
        queue_request(MODE_FREE, 26'h000_07FF);
        queue_request(MODE_FREE, '1);
        queue_request(MODE_FREE, 26'h010_0000);
        queue_request(MODE_ALLOC, 26'h2AA_AAAA);
        queue_request(MODE_ALLOC, '0);
        queue_request(MODE_FREE, 26'h000_0BFF);
        queue_request(MODE_ALLOC, '0);
        queue_request(MODE_ALLOC, '0);
        wait_idle();

        write_block_shift(5'd0);
        queue_random_items(100, 85, 1'b0);
        wait_idle();

        write_block_shift(5'd16);
        idle_pct = 66;
        queue_request(MODE_FREE, 26'h3FF_0000);
        queue_request(MODE_FREE, 26'h3FF_0000);
        queue_request(MODE_FREE, '1);
        queue_request(MODE_ALLOC, '0);
        queue_request(MODE_ALLOC, '1);
        queue_random_items(120, 45, 1'b1);
        wait_idle();

        write_block_shift(5'd31);
        idle_pct = 0;
        stall_pct = 66;
        queue_random_items(120, 45, 1'b1);
        wait_idle();

        write_block_shift(5'($urandom_range(30, 17)));
        idle_pct = 16;
        stall_pct = 16;
        for (int b = 0; b < 5; b++)
        begin
            queue_random_items(25, 45, 1'b1);
            wait_idle();
        end

        write_block_shift(5'd5);
        idle_pct = 0;
        stall_pct = 0;
        queue_random_items(150, 50, 1'b1);
        wait_idle();
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && predicted_results.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ fixed_block_free_list_allocator_unit.f @@
design/fbfl_pkg.sv
design/fbfl_link_mem.sv
design/fbfl_offset_conv.sv
design/fixed_block_free_list_allocator_unit.sv
bench/fixed_block_free_list_allocator_unit_test.sv
